/* rtl/core/vhc_pkg.sv */
// shared types and constants for the velocity-to-colour block
// no dependencies
package vhc_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = 2;

  // hue sectors of the six-sector rule
  typedef enum logic [2:0] {
    SEC_RED_RISE_G  = 3'd0,
    SEC_GREEN_RISE_R = 3'd1,
    SEC_GREEN_RISE_B = 3'd2,
    SEC_BLUE_RISE_G  = 3'd3,
    SEC_BLUE_RISE_R  = 3'd4,
    SEC_RED_RISE_B   = 3'd5
  } sector_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vhc_q_stat_t;

  // atan(2^-i) in 1/65536 turn
  function automatic logic [15:0] atan_turn(input int i);
    logic [15:0] r;
    case (i)
      0:       r = 16'd8192;
      1:       r = 16'd4836;
      2:       r = 16'd2555;
      3:       r = 16'd1297;
      4:       r = 16'd651;
      5:       r = 16'd326;
      6:       r = 16'd163;
      7:       r = 16'd81;
      8:       r = 16'd41;
      9:       r = 16'd20;
      10:      r = 16'd10;
      11:      r = 16'd5;
      12:      r = 16'd3;
      13:      r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/vhc_front.sv */
// front end: takes a velocity vector, forms magnitudes, axis cases and cordic start
// depends on nothing beyond its ports
module vhc_front #(
  parameter int W  = 16,
  parameter int CW = W + 3,
  parameter int QW = 2 * W + 2 * CW + 17
) (
  input  logic [W-1:0]  vel_x,
  input  logic [W-1:0]  vel_y,
  output logic [QW-1:0] item
);
  logic signed [W-1:0]  x, y;
  logic [W-1:0]         ax, ay;
  logic signed [CW-1:0] cx, cy;
  logic [15:0]          ang;
  logic                 spec;

  always_comb begin
    x    = signed'(vel_x);
    y    = signed'(vel_y);
    ax   = x[W-1] ? (~vel_x + W'(1)) : vel_x;
    ay   = y[W-1] ? (~vel_y + W'(1)) : vel_y;
    cx   = CW'(x);
    cy   = CW'(y);
    ang  = 16'd0;
    spec = 1'b0;
    // axis angles are stored before the half-turn offset added in the back end
    if (y == '0) begin
      spec = 1'b1;
      ang  = x[W-1] ? 16'd32768 : 16'd0;
    end else if (x == '0) begin
      spec = 1'b1;
      ang  = y[W-1] ? 16'd49152 : 16'd16384;
    end else if (x[W-1]) begin
      // fold into right half plane, start at half a turn
      cx  = -CW'(x);
      cy  = -CW'(y);
      ang = 16'd32768;
    end
    item = {spec, ang, cy, cx, ay, ax};
  end
endmodule

/* rtl/core/vhc_fifo.sv */
// short queue between front and back end
// depends on vhc_pkg
module vhc_fifo #(
  parameter int QW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [QW-1:0]      wdata,
  input  logic               pop,
  output logic [QW-1:0]      rdata,
  output vhc_pkg::vhc_q_stat_t stat
);
  logic [QW-1:0] mem [0:vhc_pkg::QDEPTH-1];
  logic [vhc_pkg::QPTR_BITS-1:0] wptr, rptr;
  logic [vhc_pkg::QPTR_BITS:0]   count;

  assign stat.full  = (count == (vhc_pkg::QPTR_BITS+1)'(vhc_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

/* rtl/core/vhc_back.sv */
// back end pipeline: cordic hue, integer sqrt, division by max speed, hsv to rgb
// depends on vhc_pkg
module vhc_back #(
  parameter int W  = 16,
  parameter int CW = W + 3,
  parameter int QW = 2 * W + 2 * CW + 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   full_speed,
  input  logic          q_valid,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue
);
  localparam int L1   = (W > vhc_pkg::CORDIC_STEPS) ? W : vhc_pkg::CORDIC_STEPS;
  localparam int RW   = W + 3;
  localparam int CMPW = (W > 16) ? W : 16;
  localparam int NV   = L1 + 20;

  logic en;
  logic vld [0:NV-1];

  logic [2*W-1:0]       n_s   [0:L1];
  logic [RW-1:0]        rem_s [0:L1];
  logic [W-1:0]         q_s   [0:L1];
  logic signed [CW-1:0] cx    [0:L1];
  logic signed [CW-1:0] cy    [0:L1];
  logic [15:0]          ang   [0:L1];
  logic                 spec  [0:L1];

  logic [15:0] ang_d [0:16];
  logic        sat_d [0:16];
  logic [16:0] dr    [0:16];
  logic [15:0] dq    [0:16];

  logic [16:0]    c1_v, c1_f;
  vhc_pkg::sector_t c1_sec, c2_sec;
  logic [7:0]     c2_full;
  logic [33:0]    c2_x;

  logic [W-1:0]         in_ax, in_ay;
  logic signed [CW-1:0] in_cx, in_cy;
  logic [15:0]          in_ang;
  logic                 in_spec;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;
  assign {in_spec, in_ang, in_cy, in_cx, in_ay, in_ax} = q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NV; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= q_valid;
      for (int k = 1; k < NV; k++) vld[k] <= vld[k-1];
      out_valid <= vld[NV-1];
    end
  end

  // entry stage: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      n_s[0]   <= (2*W)'(in_ax) * (2*W)'(in_ax) + (2*W)'(in_ay) * (2*W)'(in_ay);
      rem_s[0] <= '0;
      q_s[0]   <= '0;
      cx[0]    <= in_cx;
      cy[0]    <= in_cy;
      ang[0]   <= in_ang;
      spec[0]  <= in_spec;
    end
  end

  for (genvar k = 1; k <= L1; k++) begin : g_stage
    localparam int I = k - 1;
    logic [RW-1:0] r_sh, t;
    always_comb begin
      r_sh = {rem_s[k-1][RW-3:0], n_s[k-1][2*W-1 -: 2]};
      t    = RW'({q_s[k-1], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (k <= W) begin
          n_s[k] <= {n_s[k-1][2*W-3:0], 2'b00};
          if (r_sh >= t) begin
            rem_s[k] <= r_sh - t;
            q_s[k]   <= {q_s[k-1][W-2:0], 1'b1};
          end else begin
            rem_s[k] <= r_sh;
            q_s[k]   <= {q_s[k-1][W-2:0], 1'b0};
          end
        end else begin
          n_s[k]   <= n_s[k-1];
          rem_s[k] <= rem_s[k-1];
          q_s[k]   <= q_s[k-1];
        end
        spec[k] <= spec[k-1];
        if (k <= vhc_pkg::CORDIC_STEPS && !spec[k-1]) begin
          if (!cy[k-1][CW-1]) begin
            cx[k]  <= cx[k-1] + (cy[k-1] >>> I);
            cy[k]  <= cy[k-1] - (cx[k-1] >>> I);
            ang[k] <= ang[k-1] + vhc_pkg::atan_turn(I);
          end else begin
            cx[k]  <= cx[k-1] - (cy[k-1] >>> I);
            cy[k]  <= cy[k-1] + (cx[k-1] >>> I);
            ang[k] <= ang[k-1] - vhc_pkg::atan_turn(I);
          end
        end else begin
          cx[k]  <= cx[k-1];
          cy[k]  <= cy[k-1];
          ang[k] <= ang[k-1];
        end
      end
    end
  end

  // saturation check, then restoring division of speed<<16 by full_speed
  always_ff @(posedge clk) begin
    if (en) begin
      ang_d[0] <= ang[L1] + 16'd32768;
      sat_d[0] <= CMPW'(q_s[L1]) >= CMPW'(full_speed);
      dr[0]    <= 17'(q_s[L1]);
      dq[0]    <= '0;
    end
  end

  for (genvar j = 1; j <= 16; j++) begin : g_div
    logic [16:0] r2;
    assign r2 = {dr[j-1][15:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        ang_d[j] <= ang_d[j-1];
        sat_d[j] <= sat_d[j-1];
        if (r2 >= {1'b0, full_speed}) begin
          dr[j] <= r2 - {1'b0, full_speed};
          dq[j] <= {dq[j-1][14:0], 1'b1};
        end else begin
          dr[j] <= r2;
          dq[j] <= {dq[j-1][14:0], 1'b0};
        end
      end
    end
  end

  logic [18:0] h;
  assign h = 19'(ang_d[16]) * 19'd6;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_v   <= sat_d[16] ? 17'h10000 : {1'b0, dq[16]};
      c1_sec <= vhc_pkg::sector_t'(h[18:16]);
      c1_f   <= h[16] ? (17'h10000 - {1'b0, h[15:0]}) : {1'b0, h[15:0]};
    end
  end

  logic [24:0] full_p;
  assign full_p = 25'(c1_v) * 25'd255;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_sec  <= c1_sec;
      c2_full <= full_p[23:16];
      c2_x    <= 34'(c1_v) * 34'(c1_f);
    end
  end

  logic [41:0] rise_p;
  logic [7:0]  rise;
  assign rise_p = 42'(c2_x) * 42'd255;
  assign rise   = rise_p[39:32];

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= 8'd0;
      green <= 8'd0;
      blue  <= 8'd0;
      case (c2_sec)
        vhc_pkg::SEC_RED_RISE_G:   begin red <= c2_full; green <= rise;    end
        vhc_pkg::SEC_GREEN_RISE_R: begin red <= rise;    green <= c2_full; end
        vhc_pkg::SEC_GREEN_RISE_B: begin green <= c2_full; blue <= rise;    end
        vhc_pkg::SEC_BLUE_RISE_G:  begin green <= rise;    blue <= c2_full; end
        vhc_pkg::SEC_BLUE_RISE_R:  begin red <= rise;    blue <= c2_full;  end
        default:                   begin red <= c2_full; blue <= rise;     end
      endcase
    end
  end
endmodule

/* rtl/core/velocity_to_hsv_colour.sv */
// velocity vector to rgb colour: one transaction in, one out, one per cycle sustained while m_axis_tready is high
// the depth of the pipeline is set by the sqrt/cordic and divide stages
// the output register stalls the whole back pipeline; a 4-entry queue keeps input open meanwhile
// rst is synchronous: pipeline and queue empty, full_speed back to 1024
// depends on vhc_pkg, vhc_front, vhc_fifo, vhc_back
module velocity_to_hsv_colour #(
  parameter int VEL_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // vel_x, vel_y
  input  logic [((2*VEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // red, green, blue
  output logic [23:0]          m_axis_tdata
);
  localparam int W  = VEL_BITS;
  localparam int CW = W + 3;
  localparam int QW = 2 * W + 2 * CW + 17;

  logic [15:0]   full_speed;
  logic [QW-1:0] f_item, q_item;
  logic          push, pop;
  vhc_pkg::vhc_q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_speed <= 16'd1024;
    end else if (cfg_we) begin
      full_speed <= cfg_wdata;
    end
  end

  vhc_front #(.W(W), .CW(CW), .QW(QW)) u_front (
    .vel_x (s_axis_tdata[W-1:0]),
    .vel_y (s_axis_tdata[2*W-1:W]),
    .item  (f_item)
  );

  assign s_axis_tready = !q_stat.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  vhc_fifo #(.QW(QW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (q_item),
    .stat  (q_stat)
  );

  vhc_back #(.W(W), .CW(CW), .QW(QW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .full_speed (full_speed),
    .q_valid    (!q_stat.empty),
    .q_data     (q_item),
    .q_pop      (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .red        (m_axis_tdata[7:0]),
    .green      (m_axis_tdata[15:8]),
    .blue       (m_axis_tdata[23:16])
  );

  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty)) else $error("queue full and empty at once");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_out_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid) else $error("result valid right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && !$past(pop))
    else $error("result dropped or queue popped during stall");
endmodule
